/* rtl/instruction_execute_unit_assert.svh */
// Assertion macros for the instruction execute unit.
// Included by instruction_execute_unit, which checks its own logic.
`ifndef INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH
`define INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IEU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IEU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IEU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define IEU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/ieu_pkg.sv */
// Shared types and constants for the instruction execute unit.
// No dependencies.
package ieu_pkg;
    localparam int RegCount = 14;
    localparam logic [2:0] CAUSE_FILL       = 3'd0;
    localparam logic [2:0] CAUSE_BREAK      = 3'd1;
    localparam logic [2:0] CAUSE_SYSCALL    = 3'd2;
    localparam logic [2:0] CAUSE_ILLEGAL    = 3'd3;
    localparam logic [2:0] CAUSE_MISALIGNED = 3'd4;
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_LDSB = 3'd1;
    localparam logic [2:0] KIND_LDB  = 3'd2;
    localparam logic [2:0] KIND_LDSW = 3'd3;
    localparam logic [2:0] KIND_LDW  = 3'd4;
    localparam logic [2:0] KIND_LD   = 3'd5;
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [3:0] F_PC  = 4'd0;
    localparam logic [3:0] F_IMM = 4'd15;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        burst_break;
        logic        exception_valid;
        logic [2:0]  exception_cause;
        logic        mem_valid;
        logic        mem_write;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic [31:0] mem_wdata;
    } t_result;
endpackage

/* rtl/instruction_execute_unit.sv */
// Instruction execute unit: decode, execute and register file in one module.
// Depends on ieu_pkg and instruction_execute_unit_assert.svh.
//
//  channel | dir | tdata (low bit up)                           | tuser
//  s_axis  | in  | inst_code, imm_value, inst_size, current_pc,  | operation
//          |     | load_data (115 bits, padded to 120)          |
//  m_axis  | out | next_pc, burst_break, exception_valid,        | -
//          |     | exception_cause, mem_valid, mem_write,        |
//          |     | mem_size, mem_address, mem_wdata             |
//          |     | (105 bits, padded to 112)                    |
//
// One transaction per cycle: execute is one combinational pass from the
// input handshake into the result register, so a result appears in the cycle
// after acceptance. Input is taken whenever the result register is empty or
// drained in the same cycle. Reset (synchronous) clears registers, task PC,
// context and pending load. A stalled output holds the result and stops input.
`include "instruction_execute_unit_assert.svh"
module instruction_execute_unit import ieu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // inst_code[15:0], imm_value[47:16], inst_size[50:48], current_pc[82:51],
    // load_data[114:83], zero pad
    input  logic [119:0] s_axis_tdata,
    // operation
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc, burst_break, exception_valid, exception_cause, mem_valid,
    // mem_write, mem_size, mem_address, mem_wdata (low bit up), zero pad
    output logic [111:0] m_axis_tdata
);
    logic [31:0] r_regs [RegCount];
    logic [31:0] r_task_pc, n_task_pc;
    logic        r_ctx, n_ctx;
    logic [3:0]  r_pdest, n_pdest;
    logic [2:0]  r_pkind, n_pkind;
    logic        r_ovalid;
    t_result     r_res, n_res;
    logic        wr_en;
    logic [3:0]  wr_f;
    logic [31:0] wr_v;

    logic        accept;
    logic [15:0] ic;
    logic [31:0] imm, pc, npc, ldata;
    logic [3:0]  fc, fb, fa, fd;
    logic [31:0] va, vb;

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign ic    = s_axis_tdata[15:0];
    assign imm   = s_axis_tdata[47:16];
    assign pc    = s_axis_tdata[82:51];
    assign ldata = s_axis_tdata[114:83];
    assign npc   = pc + {29'd0, s_axis_tdata[50:48]};
    assign fc = ic[15:12];
    assign fb = ic[11:8];
    assign fa = ic[7:4];
    assign fd = ic[3:0];

    function automatic logic [31:0] rd(input logic [3:0] f, input logic [31:0] p,
                                       input logic [31:0] im,
                                       input logic [31:0] rf [RegCount]);
        logic [31:0] v;
        if (f == F_PC) v = p;
        else if (f == F_IMM) v = im;
        else v = rf[f - 4'd1];
        return v;
    endfunction

    assign va = rd(fa, pc, imm, r_regs);
    assign vb = rd(fb, pc, imm, r_regs);

    // Multiplier products, shifts and the load/store address
    logic [63:0] prod_u;
    logic [31:0] mulhs, sar_v, ldst_addr;
    logic [4:0]  sh;
    assign prod_u = {32'd0, va} * {32'd0, vb};
    assign sh = vb[4:0];
    assign sar_v = 32'($signed(va) >>> sh);
    assign mulhs = prod_u[63:32] - (va[31] ? vb : 32'd0) - (vb[31] ? va : 32'd0);
    assign ldst_addr = (fb[3] == 1'b0) ? va : ((fa == F_IMM) ? imm : imm + va);

    // Execute one transaction
    always_comb begin
        logic        ill, take, brk_cmp;
        logic [31:0] v, tva, sa, sb, off, ld;
        logic [2:0]  op;
        logic [1:0]  sz;
        logic        mis;
        n_res = '0;
        n_task_pc = r_task_pc;
        n_ctx = r_ctx;
        n_pdest = r_pdest;
        n_pkind = r_pkind;
        wr_en = 1'b0;
        wr_f = fd;
        wr_v = '0;
        ill = 1'b0;
        take = 1'b0;
        brk_cmp = 1'b1;
        v = '0;
        tva = va;
        sa = va ^ 32'h8000_0000;
        sb = vb ^ 32'h8000_0000;
        off = imm & ~32'd3;
        op = fb[2:0];
        sz = SZ_HALF;
        mis = 1'b0;
        ld = ldata;
        if (s_axis_tuser) begin
            if (r_pkind != KIND_NONE) begin
                case (r_pkind)
                    KIND_LDSB: ld = {{24{ldata[7]}}, ldata[7:0]};
                    KIND_LDB:  ld = {24'd0, ldata[7:0]};
                    KIND_LDSW: ld = {{16{ldata[15]}}, ldata[15:0]};
                    KIND_LDW:  ld = {16'd0, ldata[15:0]};
                    default:   ld = ldata;
                endcase
                wr_en = 1'b1;
                wr_f = r_pdest;
                wr_v = ld;
                n_pkind = KIND_NONE;
            end
        end else begin
            n_pkind = KIND_NONE;
            n_res.next_pc = npc;
            if (fc == 4'hf) begin
                // Load/store
                if (!fb[3] && fa == F_IMM) begin
                    if (op != 3'd4) ill = 1'b1;
                    else begin wr_en = 1'b1; wr_v = imm; end
                end else if (!fb[3] && fd == F_IMM) begin
                    ill = 1'b1;
                end else begin
                    sz = (op == 3'd0 || op == 3'd1 || op == 3'd5) ? SZ_BYTE :
                         (op == 3'd4 || op == 3'd7) ? SZ_WORD : SZ_HALF;
                    mis = (sz == SZ_HALF && ldst_addr[0]) ||
                          (sz == SZ_WORD && ldst_addr[1:0] != 2'd0);
                    if (!mis) begin
                        n_res.mem_valid = 1'b1;
                        n_res.mem_size = sz;
                        n_res.mem_address = ldst_addr;
                        if (op >= 3'd5) begin
                            n_res.mem_write = 1'b1;
                            n_res.mem_wdata = (fd == F_IMM) ? r_task_pc :
                                              rd(fd, pc, imm, r_regs);
                        end else begin
                            n_pkind = op + 3'd1;
                            n_pdest = fd;
                        end
                    end
                end
            end else if (fd == 4'hf) begin
                // Branch
                if (fb != F_IMM && fa != F_IMM) begin
                    case (fc)
                        4'h0: take = va == vb;
                        4'h1: take = va != vb;
                        4'h2: take = sa > sb;
                        4'h3: take = sa <= sb;
                        4'h4: take = va > vb;
                        4'h5: take = va <= vb;
                        4'h6: begin
                            case (fa)
                                4'h0: take = vb == 32'd0;
                                4'h1: take = vb != 32'd0;
                                4'h2: take = vb[31];
                                4'h3: take = !vb[31];
                                4'h4: take = !vb[31] && vb != 32'd0;
                                4'h5: take = vb[31] || vb == 32'd0;
                                default: ill = 1'b1;
                            endcase
                        end
                        default: ill = 1'b1;
                    endcase
                end else if (fb == F_IMM && fa != F_IMM) begin
                    if (fc > 4'hb) ill = 1'b1;
                    else take = va[fc];
                end else if (fa == F_IMM && fb != F_IMM) begin
                    if (fc > 4'hb) ill = 1'b1;
                    else take = !vb[fc];
                end else ill = 1'b1;
                if (take) n_res.next_pc = imm[0] ? pc + off : off;
                n_res.burst_break = brk_cmp;
            end else begin
                // ALU
                wr_en = 1'b1;
                case (fc)
                    4'h0: begin
                        if (fb == fa && fb != F_IMM) begin
                            wr_en = 1'b0;
                            case (fa)
                                4'h0: begin n_res.exception_valid = 1'b1;
                                    n_res.exception_cause = CAUSE_FILL; end
                                4'h1: begin n_res.exception_valid = 1'b1;
                                    n_res.exception_cause = CAUSE_BREAK; end
                                4'h2: begin n_res.exception_valid = 1'b1;
                                    n_res.exception_cause = CAUSE_SYSCALL; end
                                4'h3: n_ctx = 1'b1;
                                4'hd, 4'he: ;
                                default: ill = 1'b1;
                            endcase
                            if (fd != 4'd0) begin
                                wr_en = 1'b1;
                                n_res.exception_valid = 1'b0;
                                n_res.exception_cause = '0;
                                n_ctx = r_ctx;
                                ill = 1'b0;
                                v = va ^ vb;
                            end
                        end else if (fb == F_IMM) ill = 1'b1;
                        else v = va ^ vb;
                    end
                    4'h1: begin
                        if (fb == F_IMM) ill = 1'b1;
                        if (fd == 4'd0 && fb == 4'd0) n_res.burst_break = 1'b1;
                        v = va | vb;
                    end
                    4'h2: begin
                        if (fd == 4'd0 && fb == fa && fb != F_IMM)
                            v = {va[7:0], va[15:8], va[23:16], va[31:24]};
                        else if (fb == F_IMM) ill = 1'b1;
                        else v = va & vb;
                    end
                    4'h3: begin
                        if (fd == 4'd0 && fb == fa && fb != F_IMM)
                            v = {va[15:0], va[31:16]};
                        else if (fb == F_IMM) ill = 1'b1;
                        else v = va - vb;
                    end
                    4'h4: begin
                        if (fb == F_IMM) ill = 1'b1;
                        v = va + vb;
                    end
                    4'h5: v = va << sh;
                    4'h6: v = va >> sh;
                    4'h7: v = sar_v;
                    4'h8: begin
                        if (fb == 4'd0) begin
                            if (fa == 4'd0 && !r_ctx) tva = r_task_pc;
                            if (fd == 4'd0 && !r_ctx) begin
                                n_task_pc = tva;
                                wr_en = 1'b0;
                            end
                            v = tva;
                        end else if (fb == F_IMM) ill = 1'b1;
                        else v = prod_u[31:0];
                    end
                    4'h9: begin
                        if (fb == 4'd0 && fa == 4'd0) ill = 1'b1;
                        else if (fb == 4'd0) v = va + 32'd1;
                        else if (fa == 4'd0) v = va - 32'd1;
                        else if (fb == F_IMM) ill = 1'b1;
                        else v = prod_u[31:0];
                    end
                    4'ha: begin
                        if (fb == 4'd0 && fa == 4'd0) ill = 1'b1;
                        else if (fb == 4'd0) v = 32'd0 - va;
                        else if (fa == 4'd0) v = ~va;
                        else if (fb == F_IMM) ill = 1'b1;
                        else v = mulhs;
                    end
                    4'hb: begin
                        if (fb == 4'd0 || fa == 4'd0 || fb == F_IMM) ill = 1'b1;
                        else v = prod_u[63:32];
                    end
                    default: ill = 1'b1;
                endcase
                wr_v = v;
            end
            if (ill || mis) begin
                n_res = '0;
                n_res.next_pc = pc;
                n_res.burst_break = 1'b1;
                n_res.exception_valid = 1'b1;
                n_res.exception_cause = ill ? CAUSE_ILLEGAL : CAUSE_MISALIGNED;
                wr_en = 1'b0;
                n_task_pc = r_task_pc;
            end
            if (n_res.exception_valid) begin
                n_ctx = 1'b0;
                n_pkind = KIND_NONE;
                n_res.burst_break = 1'b1;
            end
        end
        // Destination write for the PC and task PC fields
        if (wr_en && wr_f == F_PC) begin
            n_res.next_pc = wr_v;
            if (s_axis_tuser) n_res.burst_break = 1'b1;
        end
        if (wr_en && wr_f == F_IMM) n_task_pc = wr_v;
    end

    // Hold state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RegCount; i++) r_regs[i] <= '0;
            r_task_pc <= '0;
            r_ctx <= 1'b0;
            r_pdest <= '0;
            r_pkind <= KIND_NONE;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_task_pc <= n_task_pc;
                r_ctx <= n_ctx;
                r_pdest <= n_pdest;
                r_pkind <= n_pkind;
                if (wr_en && wr_f != F_PC && wr_f != F_IMM)
                    r_regs[wr_f - 4'd1] <= wr_v;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_res <= n_res;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, r_res.mem_wdata, r_res.mem_address, r_res.mem_size,
                           r_res.mem_write, r_res.mem_valid, r_res.exception_cause,
                           r_res.exception_valid, r_res.burst_break, r_res.next_pc};

    `IEU_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n,
        (r_ovalid && !m_axis_tready) |=> $stable(r_res), "result changed while stalled")
    `IEU_ASSERT_IMPL(a_no_accept_stall, i_clk, i_rst_n,
        (r_ovalid && !m_axis_tready) |-> !s_axis_tready, "input taken while stalled")
    `IEU_ASSERT_IMPL(a_exc_ctx, i_clk, i_rst_n,
        (accept && n_res.exception_valid) |=> (!r_ctx && r_pkind == KIND_NONE),
        "exception left context or load pending")
    `IEU_ASSERT_IMPL(a_exc_nomem, i_clk, i_rst_n,
        (r_ovalid && r_res.exception_valid) |-> !r_res.mem_valid,
        "exception with memory request")
endmodule

/* dv/instruction_execute_unit_tb.sv */
// Self-checking testbench for instruction_execute_unit: directed rows, then random traffic.
// Each transaction is checked against a cycle-free predictor of the unit or, for some directed rows, a given result.
// Depends on ieu_pkg and the instruction_execute_unit RTL.
`timescale 1ns / 1ps
module instruction_execute_unit_tb;
    import ieu_pkg::*;

    typedef struct {
        logic        is_data;
        logic [15:0] inst;
        logic [31:0] imm;
        logic [2:0]  size;
        logic [31:0] pc;
        logic [31:0] ld;
    } t_item;

    typedef struct {
        t_item   it;
        logic    typed;
        t_result res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // inst_code, imm_value, inst_size, current_pc, load_data, zero pad
    logic [119:0] s_axis_tdata;
    // operation
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // next_pc, burst_break, exception_valid, exception_cause, mem_valid,
    // mem_write, mem_size, mem_address, mem_wdata, zero pad
    logic [111:0] m_axis_tdata;

    // Predictor state
    logic [31:0] gpr [RegCount];
    logic [31:0] tsk_pc;
    logic        in_task;
    logic [3:0]  ld_dest;
    logic [2:0]  ld_kind;

    t_result predicted_results [$];
    t_row    directed_rows [$];
    bit      failed;
    int      send_idle;
    int      recv_stall;
    bit      hold_go;
    bit      hold_done;

    instruction_execute_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Operand read: field 0 is the PC, 15 the immediate, others a register
    function automatic logic [31:0] operand(logic [3:0] f, logic [31:0] pc, logic [31:0] imm);
        if (f == F_PC) return pc;
        if (f == F_IMM) return imm;
        return gpr[f - 4'd1];
    endfunction

    task automatic write_dest(input logic [3:0] f, input logic [31:0] v, inout t_result r);
        if (f == F_PC) r.next_pc = v;
        else if (f == F_IMM) tsk_pc = v;
        else gpr[f - 4'd1] = v;
    endtask

    task automatic trap(inout t_result r, input logic [2:0] cause, input logic [31:0] pc);
        r.next_pc = pc;
        r.burst_break = 1'b1;
        r.exception_valid = 1'b1;
        r.exception_cause = cause;
        r.mem_valid = 1'b0;
        in_task = 1'b0;
        ld_kind = KIND_NONE;
    endtask

    task automatic alu_op(input logic [3:0] c, b, a, d, input logic [31:0] pc, imm, npc,
                          inout t_result r);
        logic [31:0] va, vb, v;
        logic        ill;
        longint      sp;
        logic [63:0] up;
        va = operand(a, pc, imm);
        vb = operand(b, pc, imm);
        v = '0;
        ill = 1'b0;
        r.next_pc = npc;
        sp = longint'($signed(va)) * longint'($signed(vb));
        up = {32'b0, va} * {32'b0, vb};
        case (c)
            4'h0: begin
                // System group: fill, break, syscall, enter task, no-ops
                if (d == 0 && b == a && b != F_IMM) begin
                    case (a)
                        4'd0: trap(r, CAUSE_FILL, npc);
                        4'd1: trap(r, CAUSE_BREAK, npc);
                        4'd2: trap(r, CAUSE_SYSCALL, npc);
                        4'd3: in_task = 1'b1;
                        4'd13, 4'd14: ;
                        default: trap(r, CAUSE_ILLEGAL, pc);
                    endcase
                    return;
                end
                if (b == F_IMM) ill = 1'b1;
                else v = va ^ vb;
            end
            4'h1: begin
                if (b == F_IMM) ill = 1'b1;
                else begin
                    if (d == 0 && b == 0) r.burst_break = 1'b1;
                    v = va | vb;
                end
            end
            4'h2: begin
                if (d == 0 && b == a && b != F_IMM) v = {va[7:0], va[15:8], va[23:16], va[31:24]};
                else if (b == F_IMM) ill = 1'b1;
                else v = va & vb;
            end
            4'h3: begin
                if (d == 0 && b == a && b != F_IMM) v = {va[15:0], va[31:16]};
                else if (b == F_IMM) ill = 1'b1;
                else v = va - vb;
            end
            4'h4: begin
                if (b == F_IMM) ill = 1'b1;
                else v = va + vb;
            end
            4'h5: v = va << vb[4:0];
            4'h6: v = va >> vb[4:0];
            4'h7: v = $signed(va) >>> vb[4:0];
            4'h8: begin
                // Move; in scheduler context a PC field names the task PC
                if (b == 0) begin
                    if (a == 0 && !in_task) va = tsk_pc;
                    if (d == 0 && !in_task) begin
                        tsk_pc = va;
                        return;
                    end
                    v = va;
                end else if (b == F_IMM) ill = 1'b1;
                else v = va * vb;
            end
            4'h9: begin
                if (b == 0 && a == 0) ill = 1'b1;
                else if (b == 0) v = va + 1;
                else if (a == 0) v = va - 1;
                else if (b == F_IMM) ill = 1'b1;
                else v = va * vb;
            end
            4'ha: begin
                if (b == 0 && a == 0) ill = 1'b1;
                else if (b == 0) v = -va;
                else if (a == 0) v = ~va;
                else if (b == F_IMM) ill = 1'b1;
                else v = sp[63:32];
            end
            4'hb: begin
                if (b == 0 || a == 0 || b == F_IMM) ill = 1'b1;
                else v = up[63:32];
            end
            default: ill = 1'b1;
        endcase
        if (ill) trap(r, CAUSE_ILLEGAL, pc);
        else write_dest(d, v, r);
    endtask

    task automatic branch_op(input logic [3:0] c, b, a, input logic [31:0] pc, imm, npc,
                             inout t_result r);
        logic [31:0] va, vb, off;
        logic        take;
        va = operand(a, pc, imm);
        vb = operand(b, pc, imm);
        off = {imm[31:2], 2'b00};
        take = 1'b0;
        if (b != F_IMM && a != F_IMM) begin
            case (c)
                4'h0: take = va == vb;
                4'h1: take = va != vb;
                4'h2: take = $signed(va) > $signed(vb);
                4'h3: take = $signed(va) <= $signed(vb);
                4'h4: take = va > vb;
                4'h5: take = va <= vb;
                4'h6: begin
                    case (a)
                        4'd0: take = vb == 0;
                        4'd1: take = vb != 0;
                        4'd2: take = $signed(vb) < 0;
                        4'd3: take = $signed(vb) >= 0;
                        4'd4: take = $signed(vb) > 0;
                        4'd5: take = $signed(vb) <= 0;
                        default: begin
                            trap(r, CAUSE_ILLEGAL, pc);
                            return;
                        end
                    endcase
                end
                default: begin
                    trap(r, CAUSE_ILLEGAL, pc);
                    return;
                end
            endcase
        end else if (b == F_IMM && a != F_IMM) begin
            if (c > 4'hb) begin
                trap(r, CAUSE_ILLEGAL, pc);
                return;
            end
            take = va[c];
        end else if (a == F_IMM && b != F_IMM) begin
            if (c > 4'hb) begin
                trap(r, CAUSE_ILLEGAL, pc);
                return;
            end
            take = !vb[c];
        end else begin
            trap(r, CAUSE_ILLEGAL, pc);
            return;
        end
        r.next_pc = take ? (imm[0] ? pc + off : off) : npc;
        r.burst_break = 1'b1;
    endtask

    task automatic mem_op(input logic [3:0] b, a, d, input logic [31:0] pc, imm, npc,
                          inout t_result r);
        logic [2:0]  op;
        logic [31:0] addr;
        logic [1:0]  sz;
        op = b[2:0];
        r.next_pc = npc;
        // Load immediate form
        if (!b[3] && a == F_IMM) begin
            if (op != 3'd4) trap(r, CAUSE_ILLEGAL, pc);
            else write_dest(d, imm, r);
            return;
        end
        if (!b[3]) begin
            if (d == F_IMM) begin
                trap(r, CAUSE_ILLEGAL, pc);
                return;
            end
            addr = operand(a, pc, imm);
        end else begin
            addr = (a == F_IMM) ? imm : imm + operand(a, pc, imm);
        end
        if (op == 3'd0 || op == 3'd1 || op == 3'd5) sz = SZ_BYTE;
        else if (op == 3'd4 || op == 3'd7) sz = SZ_WORD;
        else sz = SZ_HALF;
        if ((sz == SZ_HALF && addr[0]) || (sz == SZ_WORD && addr[1:0] != 2'b00)) begin
            trap(r, CAUSE_MISALIGNED, pc);
            return;
        end
        r.mem_valid = 1'b1;
        r.mem_size = sz;
        r.mem_address = addr;
        if (op >= 3'd5) begin
            r.mem_write = 1'b1;
            r.mem_wdata = (d == F_IMM) ? tsk_pc : operand(d, pc, imm);
        end else begin
            ld_kind = op + 3'd1;
            ld_dest = d;
        end
    endtask

    // Compute the result of one transaction and advance predictor state
    task automatic execute_item(input t_item it, output t_result r);
        logic [31:0] v, npc;
        r = '0;
        if (it.is_data) begin
            if (ld_kind != KIND_NONE) begin
                v = it.ld;
                case (ld_kind)
                    KIND_LDSB: v = {{24{v[7]}}, v[7:0]};
                    KIND_LDB:  v = {24'b0, v[7:0]};
                    KIND_LDSW: v = {{16{v[15]}}, v[15:0]};
                    KIND_LDW:  v = {16'b0, v[15:0]};
                    default: ;
                endcase
                if (ld_dest == F_PC) r.burst_break = 1'b1;
                write_dest(ld_dest, v, r);
                ld_kind = KIND_NONE;
            end
        end else begin
            npc = it.pc + {29'b0, it.size};
            ld_kind = KIND_NONE;
            if (it.inst[15:12] == 4'hf)
                mem_op(it.inst[11:8], it.inst[7:4], it.inst[3:0], it.pc, it.imm, npc, r);
            else if (it.inst[3:0] == 4'hf)
                branch_op(it.inst[15:12], it.inst[11:8], it.inst[7:4], it.pc, it.imm, npc, r);
            else
                alu_op(it.inst[15:12], it.inst[11:8], it.inst[7:4], it.inst[3:0],
                       it.pc, it.imm, npc, r);
        end
    endtask

    // Offer one transaction; entered and left at a falling edge
    task automatic offer(input t_item it, input logic typed, input t_result given);
        t_result r;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.is_data;
        s_axis_tdata <= {5'b0, it.ld, it.pc, it.size, it.imm, it.inst};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        execute_item(it, r);
        predicted_results.push_back(typed ? given : r);
        @(negedge i_clk);
    endtask

    function automatic t_result fault(logic [31:0] npc, logic [2:0] cause);
        t_result r;
        r = '0;
        r.next_pc = npc;
        r.burst_break = 1'b1;
        r.exception_valid = 1'b1;
        r.exception_cause = cause;
        return r;
    endfunction

    task automatic add_row(input logic is_data, input logic [15:0] inst, input logic [31:0] imm,
                           input logic [2:0] size, input logic [31:0] pc, input logic [31:0] ld,
                           input logic typed, input t_result res);
        t_row row;
        row.it = '{is_data, inst, imm, size, pc, ld};
        row.typed = typed;
        row.res = res;
        directed_rows.push_back(row);
    endtask

    // Random instruction, weighted toward well-formed ALU, branch and memory forms
    function automatic t_item random_item();
        t_item it;
        int    k;
        it.is_data = 1'b0;
        it.inst = 16'($urandom);
        it.imm = $urandom;
        it.size = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(6, 2));
        it.pc = $urandom;
        it.ld = $urandom;
        k = $urandom_range(99);
        if (k < 45) begin
            it.inst[15:12] = ($urandom_range(19) == 0) ? 4'($urandom_range(14, 12))
                                                      : 4'($urandom_range(11));
            it.inst[3:0] = 4'($urandom_range(14));
        end else if (k < 62) begin
            it.inst[15:12] = 4'($urandom_range(14));
            it.inst[3:0] = 4'hf;
        end else if (k < 92) begin
            it.inst[15:12] = 4'hf;
            if ($urandom_range(1)) it.imm[1:0] = 2'b00;
            if ($urandom_range(1)) it.inst[7:4] = 4'hf;
        end
        return it;
    endfunction

    // Receiver: random stalls, plus one long hold-off to back the unit up
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %h, got %h", name, exp, act);
            failed = 1'b1;
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_results.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                e = predicted_results.pop_front();
                check_field("next_pc", e.next_pc, m_axis_tdata[31:0]);
                check_field("burst_break", 32'(e.burst_break), 32'(m_axis_tdata[32]));
                check_field("exception_valid", 32'(e.exception_valid),
                            32'(m_axis_tdata[33]));
                check_field("exception_cause", 32'(e.exception_cause),
                            32'(m_axis_tdata[36:34]));
                check_field("mem_valid", 32'(e.mem_valid), 32'(m_axis_tdata[37]));
                check_field("mem_write", 32'(e.mem_write), 32'(m_axis_tdata[38]));
                check_field("mem_size", 32'(e.mem_size), 32'(m_axis_tdata[40:39]));
                check_field("mem_address", e.mem_address, m_axis_tdata[72:41]);
                check_field("mem_wdata", e.mem_wdata, m_axis_tdata[104:73]);
            end
        end
    end

    initial begin
        t_item   it;
        t_result z;
        int      n;
        int      waited;
        z = '0;
        failed = 1'b0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        for (int i = 0; i < RegCount; i++) gpr[i] = '0;
        tsk_pc = '0;
        in_task = 1'b0;
        ld_dest = '0;
        ld_kind = KIND_NONE;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;

        // Directed rows: special cases, extremes and every operation group
        add_row(1, 16'h0000, 32'h0, 3'd2, 32'h0, 32'hffffffff, 1, z);
        add_row(0, 16'h0000, 32'h0, 3'd7, 32'hfffffffe, 32'h0, 1,
                fault(32'h00000005, CAUSE_FILL));
        add_row(0, 16'h0110, 32'h0, 3'd2, 32'h100, 32'h0, 1, fault(32'h102, CAUSE_BREAK));
        add_row(0, 16'h0220, 32'h0, 3'd4, 32'h200, 32'h0, 1, fault(32'h204, CAUSE_SYSCALL));
        add_row(0, 16'h0330, 32'h0, 3'd2, 32'h300, 32'h0, 0, z);
        add_row(0, 16'h0440, 32'h0, 3'd2, 32'h400, 32'h0, 1, fault(32'h400, CAUSE_ILLEGAL));
        add_row(0, 16'hc123, 32'h0, 3'd0, 32'h500, 32'h0, 1, fault(32'h500, CAUSE_ILLEGAL));
        add_row(0, 16'hf4f1, 32'hffffffff, 3'd6, 32'h600, 32'h0, 0, z);
        add_row(0, 16'hf4f2, 32'h80000000, 3'd6, 32'h606, 32'h0, 0, z);
        add_row(0, 16'h4213, 32'h0, 3'd2, 32'h60c, 32'h0, 0, z);
        add_row(0, 16'ha214, 32'h0, 3'd2, 32'h60e, 32'h0, 0, z);
        add_row(0, 16'hb215, 32'h0, 3'd2, 32'h610, 32'h0, 0, z);
        add_row(0, 16'h7126, 32'h0, 3'd2, 32'h612, 32'h0, 0, z);
        add_row(0, 16'h3110, 32'h0, 3'd2, 32'h614, 32'h0, 0, z);
        add_row(0, 16'h012f, 32'h11, 3'd6, 32'h700, 32'h0, 0, z);
        add_row(0, 16'h5f1f, 32'h40, 3'd6, 32'h800, 32'h0, 0, z);
        add_row(0, 16'h0fff, 32'h0, 3'd6, 32'h900, 32'h0, 1, fault(32'h900, CAUSE_ILLEGAL));
        add_row(0, 16'hfcf4, 32'h1000, 3'd6, 32'ha00, 32'h0, 0, z);
        add_row(1, 16'h0000, 32'h0, 3'd0, 32'h0, 32'hdeadbeef, 0, z);
        add_row(0, 16'hfcf4, 32'h1002, 3'd6, 32'hb00, 32'h0, 1, fault(32'hb00, CAUSE_MISALIGNED));
        add_row(0, 16'hfcf0, 32'h2000, 3'd6, 32'hc00, 32'h0, 0, z);
        add_row(1, 16'h0000, 32'h0, 3'd0, 32'h0, 32'h12345678, 0, z);
        add_row(0, 16'hfdf1, 32'h3001, 3'd6, 32'hd00, 32'h0, 0, z);
        add_row(0, 16'h1020, 32'h0, 3'd2, 32'hd06, 32'h0, 0, z);
        add_row(0, 16'h8010, 32'h0, 3'd2, 32'hd08, 32'h0, 0, z);
        add_row(0, 16'hffff, 32'h4000, 3'd6, 32'hd0a, 32'h0, 0, z);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);

        // Random traffic in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  hold_go = 1'b1; end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 6; recv_stall = 6; end
            endcase
            n = 0;
            while (n < 200) begin
                if ($urandom_range(19) == 0) begin
                    it = random_item();
                    it.is_data = 1'b1;
                    offer(it, 0, z);
                end else begin
                    it = random_item();
                    offer(it, 0, z);
                    // Return the data for most accepted loads
                    if (ld_kind != KIND_NONE && $urandom_range(9) < 8) begin
                        it = random_item();
                        it.is_data = 1'b1;
                        offer(it, 0, z);
                    end
                end
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (predicted_results.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (!failed && predicted_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* instruction_execute_unit.f */
+incdir+rtl
rtl/ieu_pkg.sv
rtl/instruction_execute_unit.sv
dv/instruction_execute_unit_tb.sv
